// ===== rtl/apd_alternans_monitor_core_macros.svh =====
// Assertion macros shared by the monitor RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef APD_ALTERNANS_MONITOR_CORE_MACROS_SVH
`define APD_ALTERNANS_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define APD_AM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apd_am assertion failed");

// Next-cycle implication, checked out of reset
`define APD_AM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apd_am assertion failed");

`endif

// ===== rtl/apd_am_pkg.sv =====
// Shared types, constants and helpers of the APD alternans monitor.
// No dependencies; imported by the interfaces, the divider and the top level.
package apd_am_pkg;

  localparam int WINDOW_LEN_DEF = 11;

  localparam int TIME_W     = 32;
  localparam int VOLT_W     = 15;
  localparam int APD_W      = 24;
  localparam int ANM_W      = 32;
  localparam int AMP_W      = 15;
  localparam int THR_W      = 16;
  localparam int LONG_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 16;

  localparam logic signed [VOLT_W-1:0] V_MIN = -15'sd12800;
  localparam logic signed [VOLT_W-1:0] V_MAX = 15'sd6400;
  localparam logic [LONG_W-1:0]        LONG_LIMIT = 3'd4;

  localparam logic [APD_W-1:0]         CYCLE_LEN_RST = 24'd1000000;
  localparam logic [AMP_W-1:0]         AMP_THR_RST   = 15'd0;
  localparam logic signed [VOLT_W-1:0] REPOL_RST     = -15'sd4480;
  localparam logic [THR_W-1:0]         ANM_THR_RST   = 16'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_LEN   = 2'd0,
    CFG_AMP_THR     = 2'd1,
    CFG_REPOL_LEVEL = 2'd2,
    CFG_ANM_THR     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp a 15-bit voltage code to the physiological range
  function automatic logic signed [VOLT_W-1:0] sat_volt(input logic signed [VOLT_W-1:0] raw);
    logic signed [VOLT_W-1:0] v;
    v = raw;
    if (raw < V_MIN) v = V_MIN;
    if (raw > V_MAX) v = V_MAX;
    return v;
  endfunction

endpackage

// ===== rtl/apd_am_if.sv =====
// Valid/ready channels of the monitor: sample/evaluate input and result output.
// Depends on apd_am_pkg for the field widths.
interface apd_am_in_if import apd_am_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [TIME_W-1:0]        sample_time;
  logic signed [VOLT_W-1:0] voltage;

  modport source (output valid, mode, sample_time, voltage, input ready);
  modport sink   (input valid, mode, sample_time, voltage, output ready);
endinterface

interface apd_am_out_if import apd_am_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              apd_valid;
  logic [APD_W-1:0]  apd;
  logic              anm_valid;
  logic [ANM_W-1:0]  anm;
  logic              alternant;
  logic              too_few;

  modport source (output valid, apd_valid, apd, anm_valid, anm, alternant, too_few,
                  input ready);
  modport sink   (input valid, apd_valid, apd, anm_valid, anm, alternant, too_few,
                  output ready);
endinterface

// ===== rtl/apd_am_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on apd_am_pkg (status struct) and the assertion macro header.
`include "apd_alternans_monitor_core_macros.svh"

module apd_am_div import apd_am_pkg::*; #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output div_stat_t        stat_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    qbit   = (trial >= {1'b0, den_q});
    rem_d  = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    quo_d  = {quo_q[NUM_W-2:0], qbit};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Load operands on start, advance one bit per busy cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

  `APD_AM_ASSERT_NOW(a_div_start_idle, start_i, cnt_q == '0)
  `APD_AM_ASSERT_NOW(a_div_done_not_busy, done_q, cnt_q == '0)
  `APD_AM_ASSERT_NEXT(a_div_start_busy, start_i, cnt_q == CNT_W'(NUM_W))

endmodule

// ===== rtl/apd_alternans_monitor_core.sv =====
// Sample result: held in the input buffer, then loaded into the output register once free;
// the buffer takes the next sample once the last one is popped. Evaluate with a full window:
// the result follows the ring walk through its single read port and the bit-serial divider.
// Evaluate with too few APDs: the result takes the same path as a sample.
// Reset (async, active low): registers to defaults, tracker and counts cleared;
// the APD ring needs no clearing pass, entries are read only after being written.
`include "apd_alternans_monitor_core_macros.svh"

module apd_alternans_monitor_core import apd_am_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  apd_am_in_if.sink             in_if,
  apd_am_out_if.source          out_if
);

  localparam int PTR_W  = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = APD_W + $clog2(WINDOW_LEN);
  localparam int NUM_W  = SUM_W + $clog2(WINDOW_LEN) + FRAC_W;
  localparam int DEN_W  = SUM_W + $clog2(WINDOW_LEN);

  // Configuration registers
  logic [APD_W-1:0]         cycle_len_q;
  logic [AMP_W-1:0]         amp_thr_q;
  logic signed [VOLT_W-1:0] repol_q;
  logic [THR_W-1:0]         anm_thr_q;

  // Input buffer
  logic                     ibuf_vld_q;
  logic                     ibuf_mode_q;
  logic [TIME_W-1:0]        ibuf_time_q;
  logic signed [VOLT_W-1:0] ibuf_volt_q;

  // Waveform tracker
  logic signed [VOLT_W-1:0] prev_q, peak_q, level_q;
  logic                     primed_q, rising_q;
  logic [TIME_W-1:0]        depol_q;

  // Ring bookkeeping
  logic [PTR_W-1:0]  win_ptr_q;
  logic [CNT_W-1:0]  apd_cnt_q;
  logic [LONG_W-1:0] long_cnt_q;

  // Ring memory
  logic [APD_W-1:0] ring_mem [WINDOW_LEN];
  logic [APD_W-1:0] rdata_q;
  logic             mem_we;

  // Evaluation datapath
  state_e           st_q, st_d;
  logic [CNT_W-1:0] rd_cnt_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [APD_W-1:0] last_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] diff_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic             zero_q;
  div_stat_t        div_stat;
  logic [NUM_W-1:0] quot;
  logic             div_start;

  // Output register
  logic             out_vld_q;
  logic             o_apd_vld_q, o_anm_vld_q, o_alt_q, o_few_q;
  logic [APD_W-1:0] o_apd_q;
  logic [ANM_W-1:0] o_anm_q;
  logic             out_free;

  // FSM strobes
  logic ibuf_pop, sample_go, ev_short, rd_init, fin_load;

  // Sample path signals
  logic signed [VOLT_W-1:0] v;
  logic signed [VOLT_W:0]   swing;
  logic                     rise, fall, arm, dn_cross, up_cross;
  logic signed [VOLT_W-1:0] level_n;
  logic [TIME_W-1:0]        apd_raw;
  logic [APD_W-1:0]         apd_sat;
  logic [APD_W-1:0]         abs_diff;
  logic [ANM_W-1:0]         anm_v;
  logic                     alt_v;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_len_q <= CYCLE_LEN_RST;
      amp_thr_q   <= AMP_THR_RST;
      repol_q     <= REPOL_RST;
      anm_thr_q   <= ANM_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CYCLE_LEN:   cycle_len_q <= cfg_wdata_i[APD_W-1:0];
        CFG_AMP_THR:     amp_thr_q   <= cfg_wdata_i[AMP_W-1:0];
        CFG_REPOL_LEVEL: repol_q     <= sat_volt($signed(cfg_wdata_i[VOLT_W-1:0]));
        CFG_ANM_THR:     anm_thr_q   <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Buffer one input transfer
  assign in_if.ready = !ibuf_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ibuf_vld_q <= 1'b0;
    end else if (in_if.valid && !ibuf_vld_q) begin
      ibuf_vld_q <= 1'b1;
    end else if (ibuf_pop) begin
      ibuf_vld_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_if.valid && !ibuf_vld_q) begin
      ibuf_mode_q <= in_if.mode;
      ibuf_time_q <= in_if.sample_time;
      ibuf_volt_q <= in_if.voltage;
    end
  end

  // Peak/valley tracking, level arming and crossing detection
  always_comb begin
    v        = sat_volt(ibuf_volt_q);
    rise     = (v > prev_q) && !rising_q;
    fall     = (v < prev_q) && rising_q;
    swing    = {peak_q[VOLT_W-1], peak_q} - {prev_q[VOLT_W-1], prev_q};
    arm      = rise && (swing > $signed({1'b0, amp_thr_q}));
    level_n  = arm ? repol_q : level_q;
    dn_cross = (prev_q > level_n) && (v <= level_n);
    up_cross = (prev_q <= level_n) && (v > level_n);
    apd_raw  = ibuf_time_q - depol_q;
    apd_sat  = (|apd_raw[TIME_W-1:APD_W]) ? '1 : apd_raw[APD_W-1:0];
  end

  assign mem_we = sample_go && primed_q && dn_cross;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      peak_q   <= '0;
      level_q  <= '0;
      primed_q <= 1'b0;
      rising_q <= 1'b0;
      depol_q  <= '0;
    end else if (sample_go) begin
      prev_q <= v;
      if (!primed_q) begin
        primed_q <= 1'b1;
      end else begin
        if (rise) begin
          rising_q <= 1'b1;
        end else if (fall) begin
          rising_q <= 1'b0;
          peak_q   <= prev_q;
        end
        level_q <= level_n;
        if (up_cross) depol_q <= ibuf_time_q;
      end
    end
  end

  // Ring pointer and counts; evaluation clears them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ptr_q  <= '0;
      apd_cnt_q  <= '0;
      long_cnt_q <= '0;
    end else if (ev_short || fin_load) begin
      win_ptr_q  <= '0;
      apd_cnt_q  <= '0;
      long_cnt_q <= '0;
    end else if (mem_we) begin
      win_ptr_q <= (win_ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : win_ptr_q + 1'b1;
      if (apd_cnt_q != CNT_W'(WINDOW_LEN)) apd_cnt_q <= apd_cnt_q + 1'b1;
      if ((apd_sat > cycle_len_q) && (long_cnt_q != '1)) long_cnt_q <= long_cnt_q + 1'b1;
    end
  end

  // APD ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[win_ptr_q] <= apd_sat;
    rdata_q <= ring_mem[rd_ptr_q];
  end

  // Control FSM: state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else         st_q <= st_d;
  end

  // Control FSM: next state and strobes
  always_comb begin
    st_d      = st_q;
    ibuf_pop  = 1'b0;
    sample_go = 1'b0;
    ev_short  = 1'b0;
    rd_init   = 1'b0;
    div_start = 1'b0;
    fin_load  = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (ibuf_vld_q && out_free) begin
          ibuf_pop = 1'b1;
          if (!ibuf_mode_q) begin
            sample_go = 1'b1;
          end else if (apd_cnt_q != CNT_W'(WINDOW_LEN)) begin
            ev_short = 1'b1;
          end else begin
            rd_init = 1'b1;
            st_d    = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (rd_cnt_q == CNT_W'(WINDOW_LEN)) st_d = ST_MUL;
      end
      ST_MUL: st_d = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start = 1'b1;
        st_d      = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) st_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          fin_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Walk the ring oldest to newest; the read data is registered
  assign abs_diff = (rdata_q > last_q) ? rdata_q - last_q : last_q - rdata_q;

  always_ff @(posedge clk_i) begin
    if (rd_init) begin
      rd_ptr_q <= win_ptr_q;
      rd_cnt_q <= '0;
      sum_q    <= '0;
      diff_q   <= '0;
    end else if (st_q == ST_READ) begin
      rd_ptr_q <= (rd_ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : rd_ptr_q + 1'b1;
      rd_cnt_q <= rd_cnt_q + 1'b1;
      if (rd_cnt_q != '0) begin
        sum_q  <= sum_q + SUM_W'(rdata_q);
        last_q <= rdata_q;
        if (rd_cnt_q != CNT_W'(1)) diff_q <= diff_q + SUM_W'(abs_diff);
      end
    end else if (st_q == ST_MUL) begin
      num_q  <= (NUM_W'(diff_q) * NUM_W'(WINDOW_LEN)) << FRAC_W;
      den_q  <= DEN_W'(sum_q) * DEN_W'(WINDOW_LEN - 1);
      zero_q <= (sum_q == '0);
    end
  end

  apd_am_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // Saturate the ratio and decide alternans
  always_comb begin
    if (zero_q) anm_v = '0;
    else        anm_v = (|quot[NUM_W-1:ANM_W]) ? '1 : quot[ANM_W-1:0];
    alt_v = (anm_v > ANM_W'(anm_thr_q)) || (long_cnt_q > LONG_LIMIT);
  end

  // Output register: load a result, drop it on transfer
  assign out_free = !out_vld_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (sample_go || ev_short || fin_load) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_go) begin
      o_apd_vld_q <= mem_we;
      o_apd_q     <= mem_we ? apd_sat : '0;
      o_anm_vld_q <= 1'b0;
      o_anm_q     <= '0;
      o_alt_q     <= 1'b0;
      o_few_q     <= 1'b0;
    end else if (ev_short) begin
      o_apd_vld_q <= 1'b0;
      o_apd_q     <= '0;
      o_anm_vld_q <= 1'b0;
      o_anm_q     <= '0;
      o_alt_q     <= 1'b1;
      o_few_q     <= 1'b1;
    end else if (fin_load) begin
      o_apd_vld_q <= 1'b0;
      o_apd_q     <= '0;
      o_anm_vld_q <= 1'b1;
      o_anm_q     <= anm_v;
      o_alt_q     <= alt_v;
      o_few_q     <= 1'b0;
    end
  end

  assign out_if.valid     = out_vld_q;
  assign out_if.apd_valid = o_apd_vld_q;
  assign out_if.apd       = o_apd_q;
  assign out_if.anm_valid = o_anm_vld_q;
  assign out_if.anm       = o_anm_q;
  assign out_if.alternant = o_alt_q;
  assign out_if.too_few   = o_few_q;

  `APD_AM_ASSERT_NOW(a_ptr_in_ring, 1'b1, win_ptr_q <= PTR_W'(WINDOW_LEN - 1))
  `APD_AM_ASSERT_NOW(a_cnt_bound, 1'b1, apd_cnt_q <= CNT_W'(WINDOW_LEN))
  `APD_AM_ASSERT_NOW(a_walk_full, st_q != ST_IDLE, apd_cnt_q == CNT_W'(WINDOW_LEN))
  `APD_AM_ASSERT_NOW(a_div_busy_in_wait, div_stat.busy, st_q == ST_DIV_WAIT)

endmodule
